// ===== sv/ocu_pkg.sv =====
`default_nettype none
package ocu_pkg;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    OP_ORBIT      = 2'd0,
    OP_ZOOM       = 2'd1,
    OP_SET_TARGET = 2'd2,
    OP_SET_POS    = 2'd3
  } ocu_op_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_DIST  = 2'd0;
  localparam logic [1:0] REG_MAX_DIST  = 2'd1;
  localparam logic [1:0] REG_MAX_PITCH = 2'd2;

  // Order of the four products of the eye rebuild.
  localparam logic [1:0] MI_HORIZ = 2'd0;
  localparam logic [1:0] MI_OFF_Y = 2'd1;
  localparam logic [1:0] MI_OFF_X = 2'd2;
  localparam logic [1:0] MI_OFF_Z = 2'd3;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned XY_W = 48;
  localparam int unsigned Z_W = 36;

  localparam int PI_Q13 = 25736;
  localparam int HALF_PI_Q13 = 12868;
  localparam int TWO_PI_Q13 = 51472;
  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [47:0] GAIN_Q30 = 48'sd652032874;
  localparam logic [15:0] GAIN_HI = 16'd19898;
  localparam logic [15:0] GAIN_LO = 16'd15210;
  localparam logic [36:0] NEAR_ZERO = 37'd7;

  localparam logic [30:0] MIN_DIST_RST = 31'd6554;
  localparam logic [30:0] MAX_DIST_RST = 31'd65536000;
  localparam logic [13:0] MAX_PITCH_RST = 14'd12725;
  localparam logic signed [31:0] EYE_Z_RST = 32'sd327680;
  localparam logic [30:0] DIST_RST = 31'd327680;

  typedef struct packed {
    logic             load;
    logic             prep;
    logic             rot_ld;
    logic             vec_ld;
    logic             step;
    logic [IDX_W-1:0] step_idx;
    logic             rot_st;
    logic             pass;
    logic             mul;
    logic             mulw;
    logic [1:0]       mul_idx;
    logic             eye_upd;
    logic             diff;
    logic             gain_a;
    logic             gain_b;
    logic             sph;
    logic             out_load;
  } ocu_cmd_t;

  typedef struct packed {
    ocu_op_t op;
  } ocu_stat_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic [31:0] atan_q30(input logic [IDX_W-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ocu_req_if.sv =====
`default_nettype none
interface ocu_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [15:0] delta_yaw;
  logic signed [15:0] delta_pitch;
  logic signed [31:0] zoom_delta;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;

  modport source (output valid, operation, delta_yaw, delta_pitch, zoom_delta,
                  vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, operation, delta_yaw, delta_pitch, zoom_delta,
                vec_x, vec_y, vec_z, output ready);
endinterface
`default_nettype wire

// ===== sv/ocu_rsp_if.sv =====
`default_nettype none
interface ocu_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [15:0] yaw_out;
  logic signed [14:0] pitch_out;
  logic [30:0]        distance_out;

  modport source (output valid, eye_x, eye_y, eye_z, yaw_out, pitch_out,
                  distance_out, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, yaw_out, pitch_out,
                distance_out, output ready);
endinterface
`default_nettype wire

// ===== sv/ocu_cfg_if.sv =====
`default_nettype none
interface ocu_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/ocu_ctrl.sv =====
`default_nettype none
module ocu_ctrl
  import ocu_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire ocu_stat_t stat,
  output ocu_cmd_t       cmd
);

  localparam int unsigned CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_PREP   = 14'b00000000000010,
    S_ROT_LD = 14'b00000000000100,
    S_ROT_IT = 14'b00000000001000,
    S_ROT_ST = 14'b00000000010000,
    S_MUL    = 14'b00000000100000,
    S_MULW   = 14'b00000001000000,
    S_EYE    = 14'b00000010000000,
    S_DIFF   = 14'b00000100000000,
    S_VEC_LD = 14'b00001000000000,
    S_VEC_IT = 14'b00010000000000,
    S_GAIN_A = 14'b00100000000000,
    S_GAIN_B = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] cnt;
  logic pass;
  logic [1:0] midx;
  logic last_step;
  logic sph_pending;

  assign last_step = (cnt == CW'(CORDIC_STEPS - 1));

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.step_idx = IDX_W'(cnt);
    cmd.pass = pass;
    cmd.mul_idx = midx;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        state_next = (stat.op == OP_ORBIT || stat.op == OP_ZOOM) ? S_ROT_LD : S_DIFF;
      end
      S_ROT_LD: begin
        cmd.rot_ld = 1'b1;
        state_next = S_ROT_IT;
      end
      S_ROT_IT: begin
        cmd.step = 1'b1;
        if (last_step) state_next = S_ROT_ST;
      end
      S_ROT_ST: begin
        cmd.rot_st = 1'b1;
        state_next = pass ? S_MUL : S_ROT_LD;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_MULW;
      end
      S_MULW: begin
        cmd.mulw = 1'b1;
        state_next = (midx == MI_OFF_Z) ? S_EYE : S_MUL;
      end
      S_EYE: begin
        cmd.eye_upd = 1'b1;
        state_next = S_DONE;
      end
      S_DIFF: begin
        cmd.diff = 1'b1;
        state_next = S_VEC_LD;
      end
      S_VEC_LD: begin
        cmd.vec_ld = 1'b1;
        state_next = S_VEC_IT;
      end
      S_VEC_IT: begin
        cmd.step = 1'b1;
        if (last_step) state_next = S_GAIN_A;
      end
      S_GAIN_A: begin
        cmd.gain_a = 1'b1;
        state_next = S_GAIN_B;
      end
      S_GAIN_B: begin
        cmd.gain_b = 1'b1;
        state_next = pass ? S_DONE : S_VEC_LD;
      end
      S_DONE: begin
        // The spherical result is settled on entry here, before the response is loaded.
        cmd.sph = sph_pending;
        if (!sph_pending && (!out_valid || out_ready)) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      pass <= 1'b0;
      midx <= MI_HORIZ;
      out_valid <= 1'b0;
      sph_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.prep) pass <= 1'b0;
      if (cmd.rot_ld || cmd.vec_ld) cnt <= '0;
      else if (cmd.step) cnt <= cnt + CW'(1);
      if (cmd.rot_st) begin
        pass <= 1'b1;
        midx <= MI_HORIZ;
      end
      if (cmd.mulw) midx <= midx + 2'd1;
      if (cmd.gain_b) begin
        pass <= 1'b1;
        sph_pending <= pass;
      end
      if (cmd.sph) sph_pending <= 1'b0;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ocu_dp.sv =====
`default_nettype none
module ocu_dp
  import ocu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ocu_cmd_t           cmd,
  output ocu_stat_t               stat,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic [1:0]         operation,
  input  wire logic signed [15:0] delta_yaw,
  input  wire logic signed [15:0] delta_pitch,
  input  wire logic signed [31:0] zoom_delta,
  input  wire logic signed [31:0] vec_x,
  input  wire logic signed [31:0] vec_y,
  input  wire logic signed [31:0] vec_z,
  output logic signed [31:0]      eye_x,
  output logic signed [31:0]      eye_y,
  output logic signed [31:0]      eye_z,
  output logic signed [15:0]      yaw_out,
  output logic signed [14:0]      pitch_out,
  output logic [30:0]             distance_out
);

  localparam logic signed [18:0] PI19 = 19'(PI_Q13);
  localparam logic signed [18:0] TWO_PI19 = 19'(TWO_PI_Q13);
  localparam logic signed [18:0] HPI19 = 19'(HALF_PI_Q13);

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [18:0] wrap19(input logic signed [18:0] v);
    logic signed [18:0] r;
    if (v > PI19) r = v - TWO_PI19;
    else if (v < -PI19) r = v + TWO_PI19;
    else r = v;
    return r;
  endfunction

  // Configuration.
  logic [30:0] min_d, max_d;
  logic [13:0] max_p;

  // Request fields.
  ocu_op_t op_r;
  logic signed [15:0] dyaw_r, dpitch_r;
  logic signed [31:0] zoom_r;
  logic signed [31:0] vec_r [3];

  // Camera state.
  logic signed [31:0] tgt [3];
  logic signed [31:0] eye [3];
  logic signed [15:0] yaw;
  logic signed [14:0] pitch;
  logic [30:0] distance;

  // CORDIC stage.
  logic signed [XY_W-1:0] cx_r, cy_r;
  logic signed [Z_W-1:0] cz_r;
  logic vec_mode, neg_r, zero_r;

  // Eye rebuild.
  logic signed [33:0] cos_p, sin_p, cos_y, sin_y;
  logic signed [34:0] horiz;
  logic signed [34:0] off [3];
  logic signed [69:0] prod;

  // Spherical rebuild.
  logic signed [XY_W-1:0] ofs [3];
  logic signed [XY_W-1:0] h_r;
  logic signed [Z_W-1:0] ya, pa;
  logic [63:0] gp1, gp2;
  logic [36:0] draw;

  assign stat.op = op_r;

  // Orbit and zoom updates.
  logic signed [18:0] ysum, ysum_w;
  logic signed [16:0] psum, plim;
  logic signed [15:0] yaw_o;
  logic signed [14:0] pitch_o;
  logic signed [33:0] nd;
  logic [30:0] dist_z;

  always_comb begin
    ysum = 19'(dyaw_r) + 19'(yaw);
    ysum_w = wrap19(ysum);
    yaw_o = ysum_w[15:0];
    plim = (max_p > 14'(HALF_PI_Q13)) ? 17'(HALF_PI_Q13) : $signed({3'b000, max_p});
    psum = 17'(pitch) + 17'(dpitch_r);
    if (psum > plim) psum = plim;
    if (psum < -plim) psum = -plim;
    pitch_o = psum[14:0];
    nd = $signed({3'b000, distance}) - 34'(zoom_r);
    if (nd < $signed({3'b000, min_d})) nd = $signed({3'b000, min_d});
    if (nd > $signed({3'b000, max_d})) nd = $signed({3'b000, max_d});
    dist_z = nd[30:0];
  end

  // CORDIC load and step.
  logic signed [Z_W-1:0] za, zl, at;
  logic signed [XY_W-1:0] vx, vy, xs, ys;
  logic zneg;

  function automatic logic signed [Z_W-1:0] pass_ang(input logic p);
    logic signed [Z_W-1:0] r;
    if (p) r = Z_W'(yaw) <<< 17;
    else r = Z_W'(pitch) <<< 17;
    return r;
  endfunction

  always_comb begin
    za = pass_ang(cmd.pass);
    zneg = 1'b0;
    zl = za;
    if (za > HALF_PI_Q30) begin
      zl = za - PI_Q30;
      zneg = 1'b1;
    end else if (za < -HALF_PI_Q30) begin
      zl = za + PI_Q30;
      zneg = 1'b1;
    end
    vx = cmd.pass ? h_r : ofs[2];
    vy = cmd.pass ? ofs[1] : ofs[0];
    at = Z_W'(atan_q30(cmd.step_idx));
    xs = cx_r >>> cmd.step_idx;
    ys = cy_r >>> cmd.step_idx;
  end

  // Multiply operands.
  logic signed [34:0] ma, mb;
  logic signed [39:0] rnd;
  logic [XY_W-1:0] mag;
  logic [47:0] gsum;
  logic signed [18:0] yq, pq, yq_w;

  always_comb begin
    unique case (cmd.mul_idx)
      MI_HORIZ: begin ma = 35'($signed({1'b0, distance})); mb = 35'(cos_p); end
      MI_OFF_Y: begin ma = 35'($signed({1'b0, distance})); mb = 35'(sin_p); end
      MI_OFF_X: begin ma = horiz; mb = 35'(sin_y); end
      default:  begin ma = horiz; mb = 35'(cos_y); end
    endcase
    rnd = 40'((prod + 70'sd536870912) >>> 30);
    mag = cx_r[XY_W-1] ? '0 : cx_r;
    gsum = 48'((gp1 + gp2) >> 15);
    yq = 19'((ya + 36'sd65536) >>> 17);
    yq_w = wrap19(yq);
    pq = 19'((pa + 36'sd65536) >>> 17);
    if (pq > HPI19) pq = HPI19;
    if (pq < -HPI19) pq = -HPI19;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_d <= MIN_DIST_RST;
      max_d <= MAX_DIST_RST;
      max_p <= MAX_PITCH_RST;
      tgt[0] <= '0;
      tgt[1] <= '0;
      tgt[2] <= '0;
      eye[0] <= '0;
      eye[1] <= '0;
      eye[2] <= EYE_Z_RST;
      yaw <= '0;
      pitch <= '0;
      distance <= DIST_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_DIST:  min_d <= cfg_data;
          REG_MAX_DIST:  max_d <= cfg_data;
          REG_MAX_PITCH: max_p <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (cmd.prep) begin
        unique case (op_r)
          OP_ORBIT: begin
            yaw <= yaw_o;
            pitch <= pitch_o;
          end
          OP_ZOOM: distance <= dist_z;
          OP_SET_TARGET: for (int i = 0; i < 3; i++) tgt[i] <= vec_r[i];
          default: for (int i = 0; i < 3; i++) eye[i] <= vec_r[i];
        endcase
      end
      if (cmd.eye_upd) begin
        for (int i = 0; i < 3; i++) eye[i] <= sat32(36'(tgt[i]) + 36'(off[i]));
      end
      if (cmd.sph) begin
        if (draw < NEAR_ZERO) begin
          yaw <= '0;
          pitch <= '0;
          distance <= min_d;
        end else begin
          yaw <= yq_w[15:0];
          pitch <= pq[14:0];
          distance <= (draw > 37'h07FFFFFFF) ? 31'h7FFFFFFF : draw[30:0];
        end
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= ocu_op_t'(operation);
      dyaw_r <= delta_yaw;
      dpitch_r <= delta_pitch;
      zoom_r <= zoom_delta;
      vec_r[0] <= vec_x;
      vec_r[1] <= vec_y;
      vec_r[2] <= vec_z;
    end
    if (cmd.rot_ld) begin
      cx_r <= GAIN_Q30;
      cy_r <= '0;
      cz_r <= zl;
      neg_r <= zneg;
      zero_r <= 1'b0;
      vec_mode <= 1'b0;
    end
    if (cmd.vec_ld) begin
      vec_mode <= 1'b1;
      zero_r <= (vx == '0) && (vy == '0);
      if (vx[XY_W-1]) begin
        cx_r <= -vx;
        cy_r <= -vy;
        cz_r <= vy[XY_W-1] ? -PI_Q30 : PI_Q30;
      end else begin
        cx_r <= vx;
        cy_r <= vy;
        cz_r <= '0;
      end
    end
    if (cmd.step) begin
      if (vec_mode ? !cy_r[XY_W-1] : !cz_r[Z_W-1]) begin
        if (vec_mode) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at;
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at;
        end
      end else begin
        if (vec_mode) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at;
        end
      end
    end
    if (cmd.rot_st) begin
      if (cmd.pass) begin
        cos_y <= neg_r ? 34'(-cx_r) : 34'(cx_r);
        sin_y <= neg_r ? 34'(-cy_r) : 34'(cy_r);
      end else begin
        cos_p <= neg_r ? 34'(-cx_r) : 34'(cx_r);
        sin_p <= neg_r ? 34'(-cy_r) : 34'(cy_r);
      end
    end
    if (cmd.mul) prod <= 70'(ma) * 70'(mb);
    if (cmd.mulw) begin
      unique case (cmd.mul_idx)
        MI_HORIZ: horiz <= rnd[34:0];
        MI_OFF_Y: off[1] <= rnd[34:0];
        MI_OFF_X: off[0] <= rnd[34:0];
        default:  off[2] <= rnd[34:0];
      endcase
    end
    if (cmd.diff) begin
      for (int i = 0; i < 3; i++) ofs[i] <= (XY_W'(eye[i]) - XY_W'(tgt[i])) <<< 12;
    end
    if (cmd.gain_a) begin
      gp1 <= 64'(mag) * 64'(GAIN_HI);
      gp2 <= (64'(mag) * 64'(GAIN_LO)) >> 15;
      if (cmd.pass) pa <= zero_r ? '0 : cz_r;
      else ya <= zero_r ? '0 : cz_r;
    end
    if (cmd.gain_b) begin
      if (cmd.pass) draw <= 37'((49'(gsum) + 49'd2048) >> 12);
      else h_r <= $signed(gsum);
    end
    if (cmd.out_load) begin
      eye_x <= eye[0];
      eye_y <= eye[1];
      eye_z <= eye[2];
      yaw_out <= yaw;
      pitch_out <= pitch;
      distance_out <= distance;
    end
  end

endmodule
`default_nettype wire

// ===== sv/orbit_camera_update.sv =====
`default_nettype none
// Orbit camera update engine. The block holds a target point, an eye position and the
// spherical view of the eye around the target (yaw, pitch, distance) and takes one request
// at a time: orbit (0) adds angle deltas and clamps pitch, zoom (1) subtracts from the
// distance and clamps it to the configured limits, set target (2) and set position (3)
// load a new point and recompute yaw, pitch and distance from the offset. Every request
// returns one response with the eye, yaw, pitch and distance after the update. Positions
// are Q16.16, yaw is Q3.13 and pitch Q2.13 radians. Every request makes two passes
// through the single shared CORDIC stage, one step per cycle. A finished response sits in
// an output register, so a new request is accepted as soon as the engine is idle even if
// the previous response has not been taken yet. The configuration port is always ready;
// writes are meant to land only while the engine is idle.
module orbit_camera_update
  import ocu_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  ocu_req_if.sink   req,
  ocu_rsp_if.source rsp,
  ocu_cfg_if.sink   cfg
);

  ocu_cmd_t  cmd;
  ocu_stat_t stat;

  // Configuration writes complete in the cycle they are presented.
  assign cfg.ready = 1'b1;

  // The controller sequences the shared CORDIC stage, the multiplier and the
  // response register; it sees only the operation code of the request.
  ocu_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the camera state, the configuration and all arithmetic.
  ocu_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .operation   (req.operation),
    .delta_yaw   (req.delta_yaw),
    .delta_pitch (req.delta_pitch),
    .zoom_delta  (req.zoom_delta),
    .vec_x       (req.vec_x),
    .vec_y       (req.vec_y),
    .vec_z       (req.vec_z),
    .eye_x       (rsp.eye_x),
    .eye_y       (rsp.eye_y),
    .eye_z       (rsp.eye_z),
    .yaw_out     (rsp.yaw_out),
    .pitch_out   (rsp.pitch_out),
    .distance_out(rsp.distance_out)
  );

  // The engine works on one request at a time, so it must go busy after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while engine still busy");

  // Pitch never leaves plus or minus pi/2.
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.pitch_out <= 15'sd12868 && rsp.pitch_out >= -15'sd12868))
    else $error("pitch out of range");

  // Yaw stays wrapped to plus or minus pi.
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.yaw_out <= 16'sd25736 && rsp.yaw_out >= -16'sd25736))
    else $error("yaw out of range");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
  import ocu_pkg::*;

  // Eye, angles and distance that one request leaves behind.
  typedef struct {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic [30:0]        distance;
  } view_t;

  // Arctangent of 2^-i in Q2.30, kept by the predictor itself.
  localparam longint ATAN_TAB [0:15] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
  };
  localparam int     STEPS      = 16;
  localparam int     IDLE_LIMIT = 20000;
  localparam int     DRAIN_WAIT = 80;
  // An index that names no register.
  localparam logic [1:0] REG_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ocu_req_if req ();
  ocu_rsp_if rsp ();
  ocu_cfg_if cfg ();

  orbit_camera_update u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always #2 clk = ~clk;

  // The predictor's own copy of the camera state and the registers.
  logic [30:0]        cam_min_dist;
  logic [30:0]        cam_max_dist;
  logic [13:0]        cam_max_pitch;
  logic signed [31:0] cam_target [3];
  logic signed [31:0] cam_eye [3];
  logic signed [15:0] cam_yaw;
  logic signed [15:0] cam_pitch;
  logic [30:0]        cam_dist;

  view_t expected_views [$];
  int    mismatches = 0;
  int    idle_cycles = 0;
  bit    quiet = 1'b0;      // no random idling on either side while set
  bit    hold_req = 1'b0;   // asks the response side for a long hold-off

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic longint wrap_angle(input longint a);
    for (int k = 0; k < 4 && a > PI_Q13; k++) a -= TWO_PI_Q13;
    for (int k = 0; k < 4 && a < -PI_Q13; k++) a += TWO_PI_Q13;
    return a;
  endfunction

  function automatic longint round_q30(input longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint to_q13(input longint z);
    return (z + 65536) >>> 17;
  endfunction

  // Takes the CORDIC gain out of a magnitude in two partial products.
  function automatic longint unsigned scale_gain(input longint unsigned m);
    longint unsigned hi, lo;
    hi = 64'd652032874 >> 15;
    lo = 64'd652032874 & 64'h7FFF;
    return (m * hi + ((m * lo) >> 15)) >> 15;
  endfunction

  function automatic longint sat_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rotation mode: cosine and sine of a Q2.30 angle, gain already folded in.
  task automatic sin_cos(input longint z, output longint c, output longint s);
    longint x, y, nx;
    bit     flip;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_TAB[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Vectoring mode: angle and raw magnitude of (x, y).
  task automatic angle_mag(input longint x, input longint y, output longint ang,
                           output longint unsigned mag);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      mag = 0;
    end else begin
      if (x < 0) begin
        z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += ATAN_TAB[i];
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= ATAN_TAB[i];
        end
        x = nx;
      end
      ang = z;
      mag = (x < 0) ? 0 : longint'(x);
    end
  endtask

  task automatic rebuild_eye();
    longint cp, sp, cy, sy, d, horiz;
    longint off [3];
    d = longint'(cam_dist);
    sin_cos(longint'(cam_pitch) * 131072, cp, sp);
    sin_cos(longint'(cam_yaw) * 131072, cy, sy);
    horiz = round_q30(d * cp);
    off[0] = round_q30(horiz * sy);
    off[1] = round_q30(d * sp);
    off[2] = round_q30(horiz * cy);
    for (int i = 0; i < 3; i++)
      cam_eye[i] = 32'(sat_word(longint'(cam_target[i]) + off[i]));
  endtask

  task automatic rebuild_spherical();
    longint o [3];
    longint ya, pa;
    longint unsigned m, h, d;
    ya = 0;
    h = 0;
    for (int i = 0; i < 3; i++)
      o[i] = (longint'(cam_eye[i]) - longint'(cam_target[i])) * 4096;
    if (o[0] != 0 || o[2] != 0) begin
      angle_mag(o[2], o[0], ya, m);
      h = scale_gain(m);
    end
    angle_mag(longint'(h), o[1], pa, m);
    d = (scale_gain(m) + 2048) / 4096;
    // An eye sitting on the target has no direction: fall back to the minimum distance.
    if (d < 7) begin
      cam_yaw = '0;
      cam_pitch = '0;
      cam_dist = cam_min_dist;
    end else begin
      cam_yaw = 16'(wrap_angle(to_q13(ya)));
      pa = to_q13(pa);
      if (pa > HALF_PI_Q13) pa = HALF_PI_Q13;
      if (pa < -HALF_PI_Q13) pa = -HALF_PI_Q13;
      cam_pitch = 16'(pa);
      cam_dist = (d > 64'h7FFFFFFF) ? 31'h7FFFFFFF : d[30:0];
    end
  endtask

  // Applies one accepted request to the predicted state and queues the view it yields.
  task automatic predict_view(input ocu_op_t op, input logic signed [15:0] dyaw,
                              input logic signed [15:0] dpitch,
                              input logic signed [31:0] dzoom,
                              input logic signed [31:0] vx, input logic signed [31:0] vy,
                              input logic signed [31:0] vz);
    longint lim, p, nd;
    view_t  v;
    case (op)
      OP_ORBIT: begin
        lim = (cam_max_pitch > HALF_PI_Q13) ? HALF_PI_Q13 : longint'(cam_max_pitch);
        p = longint'(cam_pitch) + longint'(dpitch);
        cam_yaw = 16'(wrap_angle(longint'(cam_yaw) + longint'(dyaw)));
        if (p > lim) p = lim;
        if (p < -lim) p = -lim;
        cam_pitch = 16'(p);
        rebuild_eye();
      end
      OP_ZOOM: begin
        // Minimum applies first, so the maximum wins when the limits cross.
        nd = longint'(cam_dist) - longint'(dzoom);
        if (nd < longint'(cam_min_dist)) nd = longint'(cam_min_dist);
        if (nd > longint'(cam_max_dist)) nd = longint'(cam_max_dist);
        cam_dist = 31'(nd);
        rebuild_eye();
      end
      OP_SET_TARGET: begin
        cam_target[0] = vx;
        cam_target[1] = vy;
        cam_target[2] = vz;
        rebuild_spherical();
      end
      default: begin
        cam_eye[0] = vx;
        cam_eye[1] = vy;
        cam_eye[2] = vz;
        rebuild_spherical();
      end
    endcase
    v.ex = cam_eye[0];
    v.ey = cam_eye[1];
    v.ez = cam_eye[2];
    v.yaw = cam_yaw;
    v.pitch = cam_pitch[14:0];
    v.distance = cam_dist;
    expected_views.push_back(v);
  endtask

  // Offers one request and holds it until the block takes it. Unless a random pause lowers
  // it, valid stays high on exit so that back-to-back requests follow without a gap.
  task automatic send_request(input ocu_op_t op, input logic signed [15:0] dyaw,
                              input logic signed [15:0] dpitch,
                              input logic signed [31:0] dzoom,
                              input logic signed [31:0] vx, input logic signed [31:0] vy,
                              input logic signed [31:0] vz);
    req.valid <= 1'b1;
    req.operation <= op;
    req.delta_yaw <= dyaw;
    req.delta_pitch <= dpitch;
    req.zoom_delta <= dzoom;
    req.vec_x <= vx;
    req.vec_y <= vy;
    req.vec_z <= vz;
    do @(posedge clk); while (!req.ready);
    predict_view(op, dyaw, dpitch, dzoom, vx, vy, vz);
    if (!quiet && $urandom_range(0, 99) < 11) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Lowers valid and lets every outstanding response come back.
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [30:0] data);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (index)
      REG_MIN_DIST:  cam_min_dist = data;
      REG_MAX_DIST:  cam_max_dist = data;
      REG_MAX_PITCH: cam_max_pitch = data[13:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_word();
    return $urandom();
  endfunction

  // Mostly moderate values so that the geometry stays meaningful, sometimes any bit pattern.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return rand_word();
      1:       return $signed($urandom_range(0, 64)) - 32;
      default: return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF;
    endcase
  endfunction

  // One random request. Set-position requests often land near the target to exercise
  // the degenerate offset, and orbit and zoom deltas cover their full ranges.
  task automatic send_random();
    ocu_op_t            op;
    logic signed [15:0] dy, dp;
    logic signed [31:0] dz, vx, vy, vz;
    op = ocu_op_t'($urandom_range(0, 3));
    dy = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                     : 16'($signed($urandom_range(0, 4000)) - 2000);
    dp = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                     : 16'($signed($urandom_range(0, 4000)) - 2000);
    dz = ($urandom_range(0, 4) == 0) ? rand_word()
                                     : $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh7FFFFF;
    vx = rand_coord();
    vy = rand_coord();
    vz = rand_coord();
    if (op == OP_SET_POS && $urandom_range(0, 7) == 0) begin
      vx = cam_target[0] + $signed($urandom_range(0, 4)) - 2;
      vy = cam_target[1] + $signed($urandom_range(0, 4)) - 2;
      vz = cam_target[2] + $signed($urandom_range(0, 4)) - 2;
    end
    send_request(op, dy, dp, dz, vx, vy, vz);
  endtask

  // Response side: checks each accepted response against the oldest prediction, then
  // decides readiness for the next cycle.
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_views.size() == 0) begin
          report_mismatch("unexpected response", 0, 0);
        end else begin
          view_t w;
          w = expected_views.pop_front();
          if (rsp.eye_x !== w.ex) report_mismatch("eye_x", rsp.eye_x, w.ex);
          if (rsp.eye_y !== w.ey) report_mismatch("eye_y", rsp.eye_y, w.ey);
          if (rsp.eye_z !== w.ez) report_mismatch("eye_z", rsp.eye_z, w.ez);
          if (rsp.yaw_out !== w.yaw) report_mismatch("yaw_out", rsp.yaw_out, w.yaw);
          if (rsp.pitch_out !== w.pitch) report_mismatch("pitch_out", rsp.pitch_out, w.pitch);
          if (rsp.distance_out !== w.distance)
            report_mismatch("distance_out", rsp.distance_out, w.distance);
        end
      end
      if (hold_req) begin
        hold_req <= 1'b0;
        hold_left <= 400;
        rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= quiet || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  // Watchdog: a run in which nothing moves for too long has hung.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Field extremes, every operation and the degenerate cases.
  task automatic test_directed();
    send_request(OP_ORBIT, 16'sh7FFF, 16'sh7FFF, '0, '0, '0, '0);
    send_request(OP_ORBIT, -16'sh8000, -16'sh8000, '0, '0, '0, '0);
    send_request(OP_ORBIT, 16'sd25736, 16'sd100, '0, '0, '0, '0);
    send_request(OP_ORBIT, -16'sd25736, -16'sd100, '0, '0, '0, '0);
    send_request(OP_ORBIT, 16'sd0, 16'sd0, '0, '0, '0, '0);
    send_request(OP_ZOOM, '0, '0, 32'sh7FFFFFFF, '0, '0, '0);
    send_request(OP_ZOOM, '0, '0, -32'sh80000000, '0, '0, '0);
    send_request(OP_ZOOM, '0, '0, 32'sd65536, '0, '0, '0);
    send_request(OP_SET_TARGET, '0, '0, '0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_request(OP_SET_POS, '0, '0, '0, -32'sh80000000, -32'sh80000000, -32'sh80000000);
    send_request(OP_SET_TARGET, '0, '0, '0, '0, '0, '0);
    // Eye placed exactly on the target, then just beside it.
    send_request(OP_SET_POS, '0, '0, '0, '0, '0, '0);
    send_request(OP_SET_POS, '0, '0, '0, 32'sd1, '0, 32'sd1);
    // Straight above and below: yaw comes from a zero horizontal offset.
    send_request(OP_SET_POS, '0, '0, '0, '0, 32'sd655360, '0);
    send_request(OP_SET_POS, '0, '0, '0, '0, -32'sd655360, '0);
    send_request(OP_SET_POS, '0, '0, '0, -32'sd65536, '0, '0);
    send_request(OP_SET_POS, '0, '0, '0, '0, '0, -32'sd65536);
    send_request(OP_SET_POS, '0, '0, '0, -32'sd65536, '0, -32'sd1);
    send_request(OP_SET_POS, '0, '0, '0, 32'sd65536, 32'sd65536, 32'sd65536);
    send_request(OP_ORBIT, 16'sd1000, 16'sd500, '0, '0, '0, '0);
    send_request(OP_ZOOM, '0, '0, -32'sd131072, '0, '0, '0);
  endtask

  // Register extremes, crossed distance limits and an index the block ignores.
  task automatic test_registers();
    write_register(REG_MIN_DIST, 31'd1);
    write_register(REG_MAX_DIST, 31'h7FFFFFFF);
    write_register(REG_MAX_PITCH, 31'd12868);
    send_request(OP_ZOOM, '0, '0, -32'sh80000000, '0, '0, '0);
    send_request(OP_ZOOM, '0, '0, 32'sh7FFFFFFF, '0, '0, '0);
    send_request(OP_ORBIT, '0, 16'sh7FFF, '0, '0, '0, '0);
    send_request(OP_SET_POS, '0, '0, '0, '0, '0, '0);
    write_register(REG_MAX_PITCH, 31'd0);
    write_register(REG_MIN_DIST, 31'h7FFFFFFF);
    write_register(REG_MAX_DIST, 31'd1);
    send_request(OP_ORBIT, 16'sd300, -16'sd300, '0, '0, '0, '0);
    send_request(OP_ZOOM, '0, '0, 32'sd5, '0, '0, '0);
    send_request(OP_SET_POS, '0, '0, '0, '0, '0, '0);
    write_register(REG_NONE, 31'h55555555);
    write_register(REG_MIN_DIST, 31'h2AAAAAAA);
    write_register(REG_MAX_DIST, 31'h55555555);
    write_register(REG_MAX_PITCH, 31'h2AAA);
    send_request(OP_ZOOM, '0, '0, '0, '0, '0, '0);
    send_request(OP_ORBIT, '0, -16'sh8000, '0, '0, '0, '0);
  endtask

  // Random requests under one register setting.
  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) send_random();
  endtask

  // The response side holds off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    wait_drained();
    quiet = 1'b1;
    hold_req = 1'b1;
    for (int n = 0; n < 20; n++) send_random();
    quiet = 1'b0;
    // The request side then pauses until every response has come back.
    wait_drained();
    test_random(20);
  endtask

  initial begin
    req.valid = 1'b0;
    req.operation = OP_ORBIT;
    req.delta_yaw = '0;
    req.delta_pitch = '0;
    req.zoom_delta = '0;
    req.vec_x = '0;
    req.vec_y = '0;
    req.vec_z = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_MIN_DIST;
    cfg.data = '0;
    cam_min_dist = MIN_DIST_RST;
    cam_max_dist = MAX_DIST_RST;
    cam_max_pitch = MAX_PITCH_RST;
    for (int i = 0; i < 3; i++) begin
      cam_target[i] = '0;
      cam_eye[i] = '0;
    end
    cam_eye[2] = EYE_Z_RST;
    cam_yaw = '0;
    cam_pitch = '0;
    cam_dist = DIST_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_registers();
    write_register(REG_MIN_DIST, MIN_DIST_RST);
    write_register(REG_MAX_DIST, MAX_DIST_RST);
    write_register(REG_MAX_PITCH, 31'(MAX_PITCH_RST));
    test_random(500);
    // A long stretch with no idling on either side.
    quiet = 1'b1;
    test_random(300);
    quiet = 1'b0;
    test_backpressure();
    write_register(REG_MIN_DIST, 31'd65536);
    write_register(REG_MAX_DIST, 31'd655360);
    write_register(REG_MAX_PITCH, 31'd4000);
    test_random(500);
    write_register(REG_MIN_DIST, 31'd1);
    write_register(REG_MAX_DIST, 31'h7FFFFFFF);
    write_register(REG_MAX_PITCH, 31'd12868);
    test_random(480);

    wait_drained();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
